>>> rtl/isum_pkg.sv
// shared types, constants and codes for the interval stabbing unit
package isum_pkg;

    localparam int BOUND_W = 31;
    localparam int ENTRY_W = 2 * BOUND_W;
    localparam int SLOT_W = 10;
    localparam int COUNT_W = 11;
    localparam int STATUS_W = 2;
    // wide enough to hold any table depth up to 65536 plus a slot number
    localparam int WIDE_W = 17;
    localparam int TABLE_DEPTH_DEFAULT = 1024;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MULTI  = 2'd2;

    typedef struct packed {
        logic               func;
        logic [SLOT_W-1:0]  entry_index;
        logic [BOUND_W-1:0] range_low;
        logic [BOUND_W-1:0] range_high;
        logic [BOUND_W-1:0] query_point;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] match_status;
        logic [SLOT_W-1:0]   match_index;
    } out_item_t;

    // query handed from the top level to the scanner
    typedef struct packed {
        logic [BOUND_W-1:0] point;
        logic [WIDE_W-1:0]  limit;
    } scan_req_t;

endpackage

>>> rtl/isum_ram.sv
// generic single-write, single-read ram with registered read data
module isum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/isum_scan.sv
// scan sequencer with the shared range compare, one entry per cycle
module isum_scan #(
    parameter int TABLE_DEPTH = isum_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  isum_pkg::scan_req_t              req,
    output logic                             busy,
    output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    input  logic [isum_pkg::ENTRY_W-1:0]     rd_data,
    output logic                             done,
    output isum_pkg::out_item_t              result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                          state_reg, state_next;
    logic [isum_pkg::BOUND_W-1:0]  point_reg, point_next;
    logic [CNT_W-1:0]              limit_reg, limit_next;
    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic                          pend_reg, pend_next;
    logic [IDX_W-1:0]              pend_idx_reg, pend_idx_next;
    logic                          hit_one_reg, hit_one_next;
    logic [IDX_W-1:0]              found_reg, found_next;
    logic                          done_reg, done_next;
    isum_pkg::out_item_t           result_reg, result_next;

    logic                          issue;
    logic                          hit;
    logic [isum_pkg::BOUND_W-1:0]  entry_low;
    logic [isum_pkg::BOUND_W-1:0]  entry_high;
    logic [isum_pkg::WIDE_W-1:0]   found_wide;

    // entry layout is {upper, lower}
    assign entry_low  = rd_data[isum_pkg::BOUND_W-1:0];
    assign entry_high = rd_data[isum_pkg::ENTRY_W-1:isum_pkg::BOUND_W];

    // shared compare unit: does the entry read last cycle contain the point
    assign hit = pend_reg && (entry_low <= point_reg) && (point_reg <= entry_high);

    assign issue      = (state_reg == ST_SCAN) && (issue_reg < limit_reg);
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign found_wide = isum_pkg::WIDE_W'(found_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        point_next    = point_reg;
        limit_next    = limit_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_one_next  = hit_one_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next   = ST_SCAN;
                    point_next   = req.point;
                    limit_next   = req.limit[CNT_W-1:0];
                    issue_next   = '0;
                    hit_one_next = 1'b0;
                    found_next   = '0;
                end
            end
            ST_SCAN:
            begin
                pend_next     = issue;
                pend_idx_next = issue_reg[IDX_W-1:0];
                if (issue)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (hit && hit_one_reg)
                begin
                    // second match ends the scan early
                    state_next               = ST_IDLE;
                    pend_next                = 1'b0;
                    done_next                = 1'b1;
                    result_next.match_status = isum_pkg::STATUS_MULTI;
                    result_next.match_index  = '0;
                end
                else if (!pend_reg && (issue_reg >= limit_reg))
                begin
                    // every entry in range has been compared
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (hit_one_reg)
                    begin
                        result_next.match_status = isum_pkg::STATUS_UNIQUE;
                        result_next.match_index  = found_wide[isum_pkg::SLOT_W-1:0];
                    end
                    else
                    begin
                        result_next.match_status = isum_pkg::STATUS_NONE;
                        result_next.match_index  = '0;
                    end
                end
                else if (hit)
                begin
                    hit_one_next = 1'b1;
                    found_next   = pend_idx_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            hit_one_reg <= 1'b0;
            issue_reg   <= '0;
            limit_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            hit_one_reg <= hit_one_next;
            issue_reg   <= issue_next;
            limit_reg   <= limit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        point_reg    <= point_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // a result only follows a cycle of scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SCAN))
    else $error("result strobe without a preceding scan");

    // an outstanding read only exists during a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
    else $error("pending read outside a scan");

    // the read pointer never runs past the scan limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= limit_reg))
    else $error("scan pointer beyond limit");

    // index is zero unless the match is unique
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.match_status != isum_pkg::STATUS_UNIQUE))
            |-> (result_reg.match_index == '0))
    else $error("nonzero index on a non-unique result");
`endif

endmodule

>>> rtl/interval_stabbing_unique_match.sv
// top level: range table, entry count register and query scanner
//
// Writes (func 0) store a range and give no result; busy stays low. A query
// (func 1) raises busy while the scanner reads the first min(entry_count,
// TABLE_DEPTH) table entries, one per cycle, out of the registered-read
// range ram and checks each in a single compare unit; a query ends sooner
// when a second match is found. The result shows for exactly one cycle with
// done high, the first cycle after busy falls; the receiver cannot stall it,
// so it must take every result as it appears. A new item may start in the
// cycle the result is shown. Entries that were never written must not fall
// inside the scanned range.
module interval_stabbing_unique_match #(
    parameter int TABLE_DEPTH = isum_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  isum_pkg::in_item_t            cmd,
    output logic                          busy,
    output logic                          done,
    output isum_pkg::out_item_t           result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [isum_pkg::COUNT_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [isum_pkg::COUNT_W-1:0] entry_count_reg;
    logic [isum_pkg::COUNT_W-1:0] entry_count_next;

    logic                         accept;
    logic                         wr_en;
    logic                         query_start;
    logic [isum_pkg::WIDE_W-1:0]  slot_wide;
    logic [isum_pkg::WIDE_W-1:0]  count_wide;
    logic [isum_pkg::WIDE_W-1:0]  depth_wide;
    logic [IDX_W-1:0]             rd_addr;
    logic [isum_pkg::ENTRY_W-1:0] rd_data;
    isum_pkg::scan_req_t          req;

    // entry count register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            entry_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    // item decode
    assign accept      = start && !busy;
    assign depth_wide  = isum_pkg::WIDE_W'(TABLE_DEPTH);
    assign slot_wide   = isum_pkg::WIDE_W'(cmd.entry_index);
    assign wr_en       = accept && (cmd.func == isum_pkg::FUNC_WRITE)
                         && (slot_wide < depth_wide);
    assign query_start = accept && (cmd.func == isum_pkg::FUNC_QUERY);

    // scan limit saturates at the table depth
    assign count_wide = isum_pkg::WIDE_W'(entry_count_reg);
    assign req.point  = cmd.query_point;
    assign req.limit  = (count_wide > depth_wide) ? depth_wide : count_wide;

    // range table, each entry {upper, lower}
    isum_ram #(
        .WIDTH (isum_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (slot_wide[IDX_W-1:0]),
        .wdata ({cmd.range_high, cmd.range_low}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    isum_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (query_start),
        .req     (req),
        .busy    (busy),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (done),
        .result  (result)
    );

endmodule
